@@ rtl/hgd_pkg.sv @@
// ----------------------------------------------------------------------------
// hgd_pkg
// Shared constants, result type and UTF-8 helper for the Hangul syllable
// decomposition unit.
// ----------------------------------------------------------------------------
package hgd_pkg;

  // Field widths
  localparam int unsigned CP_W    = 21;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned SIDX_W  = 14;   // syllable index, 0..11171

  // Hangul syllable block and jamo bases
  localparam logic [CP_W-1:0] S_BASE  = 21'h00AC00;
  localparam logic [CP_W-1:0] S_LIMIT = 21'h00D7A4;  // S_BASE + 11172
  localparam logic [15:0]     L_BASE  = 16'h1100;
  localparam logic [15:0]     V_BASE  = 16'h1161;
  localparam logic [15:0]     T_BASE  = 16'h11A7;

  // Byte counts
  localparam logic [COUNT_W-1:0] COUNT_NONE = 4'd0;
  localparam logic [COUNT_W-1:0] COUNT_LV   = 4'd6;
  localparam logic [COUNT_W-1:0] COUNT_LVT  = 4'd9;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] CONT_MASK  = 8'h3F;

  // One decomposed result word
  typedef struct packed {
    logic               is_syllable;
    logic [COUNT_W-1:0] byte_count;
    logic [7:0]         byte_0;
    logic [7:0]         byte_1;
    logic [7:0]         byte_2;
    logic [7:0]         byte_3;
    logic [7:0]         byte_4;
    logic [7:0]         byte_5;
    logic [7:0]         byte_6;
    logic [7:0]         byte_7;
    logic [7:0]         byte_8;
  } hgd_result_t;

  // Three-byte UTF-8 form of a code point in U+0800..U+FFFF, first byte on top
  function automatic logic [23:0] encode3(input logic [15:0] cp);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    b0 = LEAD3_MARK | {4'h0, cp[15:12]};
    b1 = CONT_MARK | ({2'b00, cp[11:6]} & CONT_MASK);
    b2 = CONT_MARK | ({2'b00, cp[5:0]} & CONT_MASK);
    return {b0, b1, b2};
  endfunction

endpackage

@@ rtl/hgd_point_if.sv @@
// ----------------------------------------------------------------------------
// hgd_point_if
// Valid/ready channel carrying one Unicode code point per word.
// ----------------------------------------------------------------------------
interface hgd_point_if;
  logic                      valid;
  logic                      ready;
  logic [hgd_pkg::CP_W-1:0]  char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

@@ rtl/hgd_jamo_if.sv @@
// ----------------------------------------------------------------------------
// hgd_jamo_if
// Valid/ready channel carrying one decomposed jamo byte group per word.
// ----------------------------------------------------------------------------
interface hgd_jamo_if;
  logic                         valid;
  logic                         ready;
  logic                         is_syllable;
  logic [hgd_pkg::COUNT_W-1:0]  byte_count;
  logic [7:0]                   byte_0;
  logic [7:0]                   byte_1;
  logic [7:0]                   byte_2;
  logic [7:0]                   byte_3;
  logic [7:0]                   byte_4;
  logic [7:0]                   byte_5;
  logic [7:0]                   byte_6;
  logic [7:0]                   byte_7;
  logic [7:0]                   byte_8;

  modport source (
    output valid, output is_syllable, output byte_count,
    output byte_0, output byte_1, output byte_2, output byte_3, output byte_4,
    output byte_5, output byte_6, output byte_7, output byte_8,
    input ready
  );
  modport sink (
    input valid, input is_syllable, input byte_count,
    input byte_0, input byte_1, input byte_2, input byte_3, input byte_4,
    input byte_5, input byte_6, input byte_7, input byte_8,
    output ready
  );
endinterface

@@ rtl/hgd_split.sv @@
// ----------------------------------------------------------------------------
// hgd_split
// Combinational split of one code point into L, V and T jamo and their
// three-byte UTF-8 forms. Constant divisions use reciprocal multiplies.
// ----------------------------------------------------------------------------
module hgd_split (
  input  logic [hgd_pkg::CP_W-1:0] char_code,
  output hgd_pkg::hgd_result_t     result
);

  logic                          in_block;
  logic [hgd_pkg::CP_W-1:0]      s_full;
  logic [hgd_pkg::SIDX_W-1:0]    s_idx;
  logic [11:0]                   s_quarter;
  logic [24:0]                   prod_l;
  logic [25:0]                   prod_q;
  logic [4:0]                    l_idx;
  logic [8:0]                    q28;
  logic [8:0]                    l_times21;
  logic [hgd_pkg::SIDX_W-1:0]    q_times28;
  logic [4:0]                    v_idx;
  logic [4:0]                    t_idx;
  logic [23:0]                   l_bytes;
  logic [23:0]                   v_bytes;
  logic [23:0]                   t_bytes;

  // Range check and syllable index
  assign in_block  = (char_code >= hgd_pkg::S_BASE) && (char_code < hgd_pkg::S_LIMIT);
  assign s_full    = char_code - hgd_pkg::S_BASE;
  assign s_idx     = s_full[hgd_pkg::SIDX_W-1:0];
  assign s_quarter = s_idx[hgd_pkg::SIDX_W-1:2];

  // L = S/588 = (S/4)/147, and S/28 = (S/4)/7, both by reciprocal over 2^20 / 2^16
  assign prod_l = 25'(s_quarter) * 25'(13'd7134);
  assign prod_q = 26'(s_quarter) * 26'(14'd9363);
  assign l_idx  = prod_l[24:20];
  assign q28    = prod_q[24:16];

  // Remainders: V = S/28 - 21*L, T = S - 28*(S/28)
  assign l_times21 = 9'({4'b0, l_idx} * 9'd21);
  assign q_times28 = 14'({5'b0, q28} * 14'd28);
  assign v_idx     = 5'(q28 - l_times21);
  assign t_idx     = 5'(s_idx - q_times28);

  // Jamo code points to UTF-8
  assign l_bytes = hgd_pkg::encode3(hgd_pkg::L_BASE + {11'b0, l_idx});
  assign v_bytes = hgd_pkg::encode3(hgd_pkg::V_BASE + {11'b0, v_idx});
  assign t_bytes = hgd_pkg::encode3(hgd_pkg::T_BASE + {11'b0, t_idx});

  // Assemble the word; everything clears outside the block
  always_comb begin
    result = '0;
    if (in_block) begin
      result.is_syllable = 1'b1;
      result.byte_0      = l_bytes[23:16];
      result.byte_1      = l_bytes[15:8];
      result.byte_2      = l_bytes[7:0];
      result.byte_3      = v_bytes[23:16];
      result.byte_4      = v_bytes[15:8];
      result.byte_5      = v_bytes[7:0];
      if (t_idx != 5'd0) begin
        result.byte_count = hgd_pkg::COUNT_LVT;
        result.byte_6     = t_bytes[23:16];
        result.byte_7     = t_bytes[15:8];
        result.byte_8     = t_bytes[7:0];
      end else begin
        result.byte_count = hgd_pkg::COUNT_LV;
      end
    end
  end

endmodule

@@ rtl/hangul_decompose_to_utf8_unit.sv @@
// ----------------------------------------------------------------------------
// hangul_decompose_to_utf8_unit
// Hangul syllable to UTF-8 jamo decomposer, one code point per word.
// ----------------------------------------------------------------------------
// Each code point word produces exactly one result word, in order. A code
// point in U+AC00..U+D7A3 yields the UTF-8 bytes of its leading, vowel and
// (when present) trailing jamo with a count of 6 or 9; anything else yields a
// cleared flag, a count of zero and zero bytes. The unit takes one word every
// cycle while the output is not stalled: a word lands in the input register,
// is decomposed by one pass of constant-reciprocal arithmetic and lands in
// the result register, from which its result is offered. The result register
// parts the two sides; a stalled output holds its word while the input
// register still takes one more. There is no configuration and no state
// beyond the two pipeline registers.
// ----------------------------------------------------------------------------
module hangul_decompose_to_utf8_unit (
  input  logic             clk,
  input  logic             rst,
  hgd_point_if.sink        point_ch,
  hgd_jamo_if.source       jamo_ch
);

  logic                         stage_valid;
  logic [hgd_pkg::CP_W-1:0]     stage_cp;
  logic                         out_valid;
  hgd_pkg::hgd_result_t         out_word;
  hgd_pkg::hgd_result_t         split_word;
  logic                         out_advance;
  logic                         stage_advance;

  // Flow control: each register moves when the one after it has room
  assign out_advance    = !out_valid || jamo_ch.ready;
  assign stage_advance  = !stage_valid || out_advance;
  assign point_ch.ready = stage_advance;

  // Hold the incoming code point
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_advance) begin
      stage_valid <= point_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance && point_ch.valid) begin
      stage_cp <= point_ch.char_code;
    end
  end

  // Decompose
  hgd_split u_split (
    .char_code (stage_cp),
    .result    (split_word)
  );

  // Capture the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && stage_valid) begin
      out_word <= split_word;
    end
  end

  // Drive the output channel
  assign jamo_ch.valid       = out_valid;
  assign jamo_ch.is_syllable = out_word.is_syllable;
  assign jamo_ch.byte_count  = out_word.byte_count;
  assign jamo_ch.byte_0      = out_word.byte_0;
  assign jamo_ch.byte_1      = out_word.byte_1;
  assign jamo_ch.byte_2      = out_word.byte_2;
  assign jamo_ch.byte_3      = out_word.byte_3;
  assign jamo_ch.byte_4      = out_word.byte_4;
  assign jamo_ch.byte_5      = out_word.byte_5;
  assign jamo_ch.byte_6      = out_word.byte_6;
  assign jamo_ch.byte_7      = out_word.byte_7;
  assign jamo_ch.byte_8      = out_word.byte_8;

endmodule

@@ rtl/hgd_checker.sv @@
// ----------------------------------------------------------------------------
// hgd_checker
// Port-level checks for the Hangul decomposition unit, bound to the top level.
// ----------------------------------------------------------------------------
module hgd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         is_syllable,
  input logic [hgd_pkg::COUNT_W-1:0]  byte_count,
  input logic [7:0]                   byte_0,
  input logic [7:0]                   byte_5,
  input logic [7:0]                   byte_6,
  input logic [7:0]                   byte_7,
  input logic [7:0]                   byte_8
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_count) && $stable(byte_0)
      && $stable(byte_8) && $stable(is_syllable))
    else $error("stalled result word changed");

  // Non-syllables carry nothing
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_syllable |-> byte_count == hgd_pkg::COUNT_NONE
      && byte_0 == 8'h00 && byte_5 == 8'h00 && byte_8 == 8'h00)
    else $error("non-syllable result carries bytes");

  // Syllables give 6 or 9 bytes led by a three-byte lead mark
  a_syllable_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_syllable |-> (byte_count == hgd_pkg::COUNT_LV
      || byte_count == hgd_pkg::COUNT_LVT) && byte_0 == 8'hE1)
    else $error("syllable result has bad count or lead byte");

  // Without a trailing jamo its bytes are zero
  a_no_trail: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count == hgd_pkg::COUNT_LV |->
      byte_6 == 8'h00 && byte_7 == 8'h00 && byte_8 == 8'h00)
    else $error("trailing bytes set with a count of six");

endmodule

bind hangul_decompose_to_utf8_unit hgd_checker u_hgd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (jamo_ch.valid),
  .out_ready   (jamo_ch.ready),
  .is_syllable (jamo_ch.is_syllable),
  .byte_count  (jamo_ch.byte_count),
  .byte_0      (jamo_ch.byte_0),
  .byte_5      (jamo_ch.byte_5),
  .byte_6      (jamo_ch.byte_6),
  .byte_7      (jamo_ch.byte_7),
  .byte_8      (jamo_ch.byte_8)
);
